FILE: rtl/wqt_pkg.sv
// Shared constants and types for the sliding-window quality trim block.
package wqt_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int MAX_READ_LEN = 65536;

  localparam int QUAL_W  = 8;
  localparam int WIN_CFG_W = 7;
  localparam int BYTE_CFG_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_ADDR_W = 2;

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int KW     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = $clog2(MAX_WINDOW * 255 + 1);
  localparam int THR_W  = $clog2(MAX_WINDOW * 510 + 1);
  localparam int CNT_W  = $clog2(MAX_READ_LEN + 1);

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_WINDOW_MEAN = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCORE_OFFSET    = 2'd2;

  localparam logic [WIN_CFG_W-1:0]  RST_WINDOW_SIZE     = 7'd5;
  localparam logic [BYTE_CFG_W-1:0] RST_MIN_WINDOW_MEAN = 8'd25;
  localparam logic [BYTE_CFG_W-1:0] RST_SCORE_OFFSET    = 8'd33;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

FILE: rtl/wqt_if.sv
// Handshake interfaces for quality bytes in and trim results out.
interface wqt_in_if;
  logic                        valid;
  logic                        ready;
  logic [wqt_pkg::QUAL_W-1:0]  quality;
  logic                        read_end;

  modport source (output valid, output quality, output read_end, input ready);
  modport sink   (input valid, input quality, input read_end, output ready);
endinterface

interface wqt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        keep_read;
  logic [wqt_pkg::CNT_W-1:0]   trim_start;
  logic                        bad_window_seen;

  modport source (output valid, output keep_read, output trim_start,
                  output bad_window_seen, input ready);
  modport sink   (input valid, input keep_read, input trim_start,
                  input bad_window_seen, output ready);
endinterface

FILE: rtl/wqt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/window_quality_trim_point.sv
// Sliding-window quality trim point: one result per read, on its last byte.
// A result passes through the s1 stage register, then the output register; s1
// stalls on a last byte while an earlier result is untaken. Throughput: one
// quality byte per cycle unless s1 stalls; the window sum is the difference of
// two prefix sums, one kept in a register and one read from a 64-entry RAM.
// Reset clears configuration to its defaults and all per-read state.
module window_quality_trim_point (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wqt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [wqt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  wqt_in_if.sink                            in_ch,
  wqt_out_if.source                         out_ch
);

  localparam int AW    = wqt_pkg::AW;
  localparam int KW    = wqt_pkg::KW;
  localparam int SUM_W = wqt_pkg::SUM_W;
  localparam int THR_W = wqt_pkg::THR_W;
  localparam int CNT_W = wqt_pkg::CNT_W;

  logic [wqt_pkg::WIN_CFG_W-1:0]  win_cfg_r;
  logic [wqt_pkg::BYTE_CFG_W-1:0] mean_cfg_r;
  logic [wqt_pkg::BYTE_CFG_W-1:0] off_cfg_r;

  wqt_pkg::count_t cnt_r, cnt_nxt;
  wqt_pkg::sum_t   prefix_r, prefix_nxt;

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_last_r;
  logic                 s1_test_r;
  logic                 s1_bypass_r;
  wqt_pkg::sum_t        s1_prefix_r;
  wqt_pkg::sum_t        s1_prev_r;
  logic [THR_W-1:0]     s1_thr_r;
  logic [KW-1:0]        s1_k_r;
  wqt_pkg::count_t      s1_cnt_r;

  logic                 bad_seen_r, bad_seen_nxt;
  wqt_pkg::count_t      last_bad_r, last_bad_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_keep_r;
  wqt_pkg::count_t      out_trim_r;
  logic                 out_bad_r;

  logic                 in_fire, s1_go, out_load, take;
  logic [KW-1:0]        k_eff;
  logic [8:0]           thr_base;
  wqt_pkg::count_t      cnt_inc;
  logic [AW-1:0]        rd_addr;
  wqt_pkg::sum_t        ram_rdata, base_sum, win_sum;
  logic                 bad_now, fin_bad;
  wqt_pkg::count_t      fin_end;
  logic [CNT_W:0]       end_plus_k, len_plus_1;
  logic                 fin_keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r  <= wqt_pkg::RST_WINDOW_SIZE;
      mean_cfg_r <= wqt_pkg::RST_MIN_WINDOW_MEAN;
      off_cfg_r  <= wqt_pkg::RST_SCORE_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wqt_pkg::REG_WINDOW_SIZE:     win_cfg_r  <= cfg_wdata[wqt_pkg::WIN_CFG_W-1:0];
        wqt_pkg::REG_MIN_WINDOW_MEAN: mean_cfg_r <= cfg_wdata;
        wqt_pkg::REG_SCORE_OFFSET:    off_cfg_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_cfg_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(win_cfg_r) > wqt_pkg::MAX_WINDOW) begin
      k_eff = KW'(wqt_pkg::MAX_WINDOW);
    end else begin
      k_eff = KW'(win_cfg_r);
    end
  end

  assign thr_base = 9'(off_cfg_r) + 9'(mean_cfg_r);

  assign take     = out_valid_r & out_ch.ready;
  assign s1_go    = s1_valid_r & (~s1_last_r | ~out_valid_r | out_ch.ready);
  assign out_load = s1_go & s1_last_r;
  assign in_ch.ready = ~s1_valid_r | s1_go;
  assign in_fire  = in_ch.valid & in_ch.ready;

  // Prefix sums are kept modulo 2**SUM_W; a window difference never wraps.
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign rd_addr = cnt_r[AW-1:0] + AW'(1) - AW'(k_eff);

  always_comb begin
    cnt_nxt    = cnt_r;
    prefix_nxt = prefix_r;
    if (in_fire) begin
      if (in_ch.read_end) begin
        cnt_nxt    = '0;
        prefix_nxt = '0;
      end else if (32'(cnt_r) < wqt_pkg::MAX_READ_LEN) begin
        cnt_nxt    = cnt_inc;
        prefix_nxt = prefix_r + SUM_W'(in_ch.quality);
      end
    end
  end

  wqt_ram #(
    .WIDTH (SUM_W),
    .DEPTH (wqt_pkg::MAX_WINDOW)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (cnt_r[AW-1:0]),
    .wdata (prefix_r),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign s1_valid_nxt = in_fire | (s1_valid_r & ~s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      prefix_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      prefix_r   <= prefix_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r   <= in_ch.read_end;
      s1_bypass_r <= (k_eff == KW'(1));
      s1_prev_r   <= prefix_r;
      s1_k_r      <= k_eff;
      s1_thr_r    <= THR_W'(k_eff * thr_base);
      if (32'(cnt_r) < wqt_pkg::MAX_READ_LEN) begin
        s1_test_r   <= (32'(cnt_inc) >= 32'(k_eff));
        s1_prefix_r <= prefix_r + SUM_W'(in_ch.quality);
        s1_cnt_r    <= cnt_inc;
      end else begin
        s1_test_r   <= 1'b0;
        s1_prefix_r <= prefix_r;
        s1_cnt_r    <= cnt_r;
      end
    end
  end

  assign base_sum = s1_bypass_r ? s1_prev_r : ram_rdata;
  assign win_sum  = s1_prefix_r - base_sum;
  assign bad_now  = s1_test_r & (THR_W'(win_sum) < s1_thr_r);

  assign fin_bad    = bad_seen_r | bad_now;
  assign fin_end    = bad_now ? s1_cnt_r : last_bad_r;
  assign end_plus_k = (CNT_W+1)'(fin_end) + (CNT_W+1)'(s1_k_r);
  assign len_plus_1 = (CNT_W+1)'(s1_cnt_r) + (CNT_W+1)'(1);
  assign fin_keep   = fin_bad ? (end_plus_k <= (CNT_W+1)'(s1_cnt_r))
                              : (len_plus_1 >= (CNT_W+1)'(s1_k_r));

  always_comb begin
    bad_seen_nxt = bad_seen_r;
    last_bad_nxt = last_bad_r;
    if (s1_go) begin
      if (s1_last_r) begin
        bad_seen_nxt = 1'b0;
        last_bad_nxt = '0;
      end else if (bad_now) begin
        bad_seen_nxt = 1'b1;
        last_bad_nxt = s1_cnt_r;
      end
    end
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_seen_r  <= 1'b0;
      last_bad_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bad_seen_r  <= bad_seen_nxt;
      last_bad_r  <= last_bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_keep_r <= fin_keep;
      out_trim_r <= fin_bad ? fin_end : '0;
      out_bad_r  <= fin_bad;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.keep_read       = out_keep_r;
  assign out_ch.trim_start      = out_trim_r;
  assign out_ch.bad_window_seen = out_bad_r;

endmodule

FILE: rtl/wqt_checker.sv
// Port-level checks for the quality trim block, bound to its top level.
module wqt_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_read_end,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_keep_read,
  input logic [wqt_pkg::CNT_W-1:0] out_trim_start,
  input logic                    out_bad_window_seen
);

  logic [2:0] pending_r, pending_nxt;
  logic       end_in, res_out;

  assign end_in  = in_valid & in_ready & in_read_end;
  assign res_out = out_valid & out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (end_in & ~res_out) begin
      pending_nxt = pending_r + 3'd1;
    end else if (res_out & ~end_in) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A result is only shown for a read whose last byte has been taken.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result shown without a pending read end");

  a_clean_read_trim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_window_seen |-> out_trim_start == '0)
    else $error("trim start not zero for a read with no bad window");

  a_bad_read_trim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_window_seen |-> out_trim_start != '0)
    else $error("trim start zero although a bad window was seen");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_keep_read)
      && $stable(out_trim_start) && $stable(out_bad_window_seen))
    else $error("stalled result transaction changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind window_quality_trim_point wqt_checker u_wqt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_read_end         (in_ch.read_end),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_keep_read       (out_ch.keep_read),
  .out_trim_start      (out_ch.trim_start),
  .out_bad_window_seen (out_ch.bad_window_seen)
);

FILE: tb/trim_result_check.sv
// Checker that predicts each read's trim result from the byte stream and compares the block's output.
module trim_result_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wqt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wqt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  wqt_in_if                              in_ch,
  wqt_out_if                             out_ch,
  output int                             failures,
  output int                             pending,
  output int                             reads_checked,
  output int                             reads_trimmed,
  output int                             reads_dropped
);
  timeunit 1ns;
  timeprecision 1ps;
  import wqt_pkg::*;

  typedef struct packed {
    logic   keep_read;
    count_t trim_start;
    logic   bad_window_seen;
  } trim_verdict_t;

  logic [QUAL_W-1:0]     recent_scores [MAX_WINDOW];
  int unsigned           read_len;
  int unsigned           last_bad_end;
  bit                    any_bad;
  logic [WIN_CFG_W-1:0]  window_cfg;
  logic [BYTE_CFG_W-1:0] mean_cfg;
  logic [BYTE_CFG_W-1:0] offset_cfg;
  trim_verdict_t         verdicts_due [$];
  int                    fail_count = 0;
  int                    checked_count = 0;
  int                    trimmed_count = 0;
  int                    dropped_count = 0;
  int                    due_count = 0;

  assign failures      = fail_count;
  assign pending       = due_count;
  assign reads_checked = checked_count;
  assign reads_trimmed = trimmed_count;
  assign reads_dropped = dropped_count;

  function automatic int unsigned window_len();
    if (window_cfg == 0) return 1;
    if (window_cfg > MAX_WINDOW) return MAX_WINDOW;
    return window_cfg;
  endfunction

  task automatic take_score(input logic [QUAL_W-1:0] q, input logic last);
    int unsigned   k;
    int unsigned   sum;
    int unsigned   limit;
    int unsigned   i;
    trim_verdict_t v;
    k = window_len();
    if (read_len < MAX_READ_LEN) begin
      recent_scores[read_len % MAX_WINDOW] = q;
      read_len++;
      if (read_len >= k) begin
        sum = 0;
        for (i = 0; i < k; i++) sum += recent_scores[(read_len - 1 - i) % MAX_WINDOW];
        limit = k * (offset_cfg + mean_cfg);
        if (sum < limit) begin
          last_bad_end = read_len;
          any_bad = 1'b1;
        end
      end
    end
    if (last) begin
      v.bad_window_seen = any_bad;
      if (any_bad) begin
        v.trim_start = count_t'(last_bad_end);
        v.keep_read  = (last_bad_end + k <= read_len);
      end else begin
        v.trim_start = '0;
        v.keep_read  = (read_len + 1 >= k);
      end
      verdicts_due.push_back(v);
      read_len     = 0;
      last_bad_end = 0;
      any_bad      = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    trim_verdict_t want;
    if (!rst_n) begin
      window_cfg   = RST_WINDOW_SIZE;
      mean_cfg     = RST_MIN_WINDOW_MEAN;
      offset_cfg   = RST_SCORE_OFFSET;
      read_len     = 0;
      last_bad_end = 0;
      any_bad      = 1'b0;
      verdicts_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result with no read outstanding: keep_read=%0b trim_start=%0d bad_window_seen=%0b",
                   $time, out_ch.keep_read, out_ch.trim_start, out_ch.bad_window_seen);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          checked_count++;
          if (want.bad_window_seen) trimmed_count++;
          if (!want.keep_read) dropped_count++;
          if (out_ch.keep_read !== want.keep_read) begin
            $display("%0t: keep_read expected %0b, got %0b", $time, want.keep_read,
                     out_ch.keep_read);
            fail_count++;
          end
          if (out_ch.trim_start !== want.trim_start) begin
            $display("%0t: trim_start expected %0d, got %0d", $time, want.trim_start,
                     out_ch.trim_start);
            fail_count++;
          end
          if (out_ch.bad_window_seen !== want.bad_window_seen) begin
            $display("%0t: bad_window_seen expected %0b, got %0b", $time,
                     want.bad_window_seen, out_ch.bad_window_seen);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_WINDOW_SIZE:     window_cfg = cfg_wdata[WIN_CFG_W-1:0];
          REG_MIN_WINDOW_MEAN: mean_cfg = cfg_wdata[BYTE_CFG_W-1:0];
          REG_SCORE_OFFSET:    offset_cfg = cfg_wdata[BYTE_CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) take_score(in_ch.quality, in_ch.read_end);
    end
    due_count <= verdicts_due.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the testbench: clock, reset, register writes, quality byte stimulus and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wqt_pkg::*;

  localparam int CYCLE_LIMIT     = 200_000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 90;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wqt_in_if  in_ch ();
  wqt_out_if out_ch ();

  int failures;
  int pending;
  int reads_checked;
  int reads_trimmed;
  int reads_dropped;

  int cycle_count = 0;
  int items_sent = 0;
  int settings_count = 0;
  int burst_left = 0;
  int cur_k = 5;
  int cur_level = 58;
  bit hold_req = 1'b0;
  int holds_done = 0;

  window_quality_trim_point dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  trim_result_check result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .failures      (failures),
    .pending       (pending),
    .reads_checked (reads_checked),
    .reads_trimmed (reads_trimmed),
    .reads_dropped (reads_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("** window_quality_trim_point: FAILED **");
      $finish;
    end
  end

  initial begin
    int mode;
    int span;
    int tick;
    out_ch.ready <= 1'b0;
    tick = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 60);
        repeat (span) begin
          case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= ($urandom_range(0, 4) != 0);
            default: out_ch.ready <= (tick % 5 < 3);
          endcase
          tick++;
          @(posedge clk);
        end
      end
    end
  end

  function automatic int clamp_window(input logic [WIN_CFG_W-1:0] k);
    if (k == 0) return 1;
    if (k > MAX_WINDOW) return MAX_WINDOW;
    return int'(k);
  endfunction

  function automatic logic [QUAL_W-1:0] near_level(input int level, input int spread);
    int v;
    v = level - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[QUAL_W-1:0];
  endfunction

  function automatic logic [WIN_CFG_W-1:0] random_window();
    if ($urandom_range(0, 3) == 0) return WIN_CFG_W'($urandom_range(0, 127));
    return WIN_CFG_W'($urandom_range(1, 12));
  endfunction

  task automatic send_byte(input logic [QUAL_W-1:0] q, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid    <= 1'b1;
    in_ch.quality  <= q;
    in_ch.read_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_run(input logic [QUAL_W-1:0] q, input int n, input logic end_read);
    int i;
    for (i = 0; i < n; i++) send_byte(q, end_read && (i == n - 1));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_CFG_W-1:0] k);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_WINDOW_SIZE;
    cfg_wdata <= {1'($urandom_range(0, 1)), k};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_k = clamp_window(k);
    settings_count++;
  endtask

  task automatic set_regs(input logic [WIN_CFG_W-1:0] k, input logic [BYTE_CFG_W-1:0] mean,
                          input logic [BYTE_CFG_W-1:0] offset);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_WINDOW_SIZE;
    cfg_wdata <= {1'($urandom_range(0, 1)), k};
    @(posedge clk);
    cfg_addr  <= REG_MIN_WINDOW_MEAN;
    cfg_wdata <= mean;
    @(posedge clk);
    cfg_addr  <= REG_SCORE_OFFSET;
    cfg_wdata <= offset;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_k     = clamp_window(k);
    cur_level = int'(mean) + int'(offset);
    settings_count++;
  endtask

  task automatic send_random_read();
    int               len;
    int               style;
    int               cut;
    int               pos;
    logic [QUAL_W-1:0] q;
    len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 140) : $urandom_range(1, cur_k + 24);
    style = $urandom_range(0, 3);
    cut   = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
    for (pos = 0; pos < len; pos++) begin
      if (cut != 0 && pos == cut) begin
        settle();
        write_window(random_window());
      end
      case (style)
        0: q = QUAL_W'($urandom_range(0, 255));
        1: q = near_level(cur_level, 6);
        2: q = ($urandom_range(0, 7) == 0) ? near_level(cur_level - 20, 10)
                                          : near_level(cur_level + 30, 30);
        default: q = near_level(cur_level, 40);
      endcase
      send_byte(q, pos == len - 1);
    end
  endtask

  initial begin
    int                    phase;
    int                    start;
    logic [WIN_CFG_W-1:0]  k;
    logic [BYTE_CFG_W-1:0] mean;
    logic [BYTE_CFG_W-1:0] offset;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_addr       <= REG_WINDOW_SIZE;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.quality  <= '0;
    in_ch.read_end <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a read shorter than the window, one just long enough to keep,
    // an all-bad read, and a read trimmed after a bad start.
    send_run(8'd0, 1, 1'b1);
    send_run(8'd255, 4, 1'b1);
    send_run(8'd0, 5, 1'b1);
    send_run(8'd0, 5, 1'b0);
    send_run(8'd255, 6, 1'b1);
    // The window shrinks in the middle of a read.
    send_run(8'd200, 3, 1'b0);
    settle();
    write_window(7'd1);
    send_byte(8'd0, 1'b1);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin k = RST_WINDOW_SIZE; mean = RST_MIN_WINDOW_MEAN; offset = RST_SCORE_OFFSET; end
        1: begin k = 7'd0; mean = 8'd0; offset = 8'd0; end
        2: begin k = 7'd64; mean = 8'd255; offset = 8'd255; end
        3: begin
          k      = 7'd127;
          mean   = BYTE_CFG_W'($urandom_range(0, 255));
          offset = BYTE_CFG_W'($urandom_range(0, 255));
        end
        4: begin
          k      = 7'd1;
          mean   = BYTE_CFG_W'($urandom_range(0, 60));
          offset = BYTE_CFG_W'($urandom_range(0, 70));
        end
        default: begin
          k      = random_window();
          mean   = ($urandom_range(0, 4) == 0) ? BYTE_CFG_W'($urandom_range(0, 255))
                                                : BYTE_CFG_W'($urandom_range(0, 60));
          offset = ($urandom_range(0, 4) == 0) ? BYTE_CFG_W'($urandom_range(0, 255))
                                                : BYTE_CFG_W'($urandom_range(0, 70));
        end
      endcase
      set_regs(k, mean, offset);
      if (phase == 4) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) send_random_read();
    end

    settle();
    $display("Checked %0d reads from %0d quality bytes over %0d register settings.",
             reads_checked, items_sent, settings_count);
    $display("%0d reads had a bad window, %0d were dropped; output held off %0d time(s).",
             reads_trimmed, reads_dropped, holds_done);
    if (failures == 0 && pending == 0) begin
      $display("** window_quality_trim_point: PASSED **");
    end else begin
      $display("** window_quality_trim_point: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/wqt_pkg.sv
rtl/wqt_if.sv
rtl/wqt_ram.sv
rtl/window_quality_trim_point.sv
rtl/wqt_checker.sv
tb/trim_result_check.sv
tb/testbench.sv
